>>> sv/arp_cache_with_request_retry_defines.svh
// Assertion macros shared by the ARP cache RTL.
`ifndef ARP_CACHE_WITH_REQUEST_RETRY_DEFINES_SVH
`define ARP_CACHE_WITH_REQUEST_RETRY_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ARPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/arpc_pkg.sv
// Package with sizes, codes and beat types of the ARP cache.
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int PEND_ENTRIES  = 8;
    localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PIDX_W = (PEND_ENTRIES > 1) ? $clog2(PEND_ENTRIES) : 1;
    localparam int SCAN_MAX = (CACHE_ENTRIES > PEND_ENTRIES) ? CACHE_ENTRIES : PEND_ENTRIES;
    localparam int SCAN_W = $clog2(SCAN_MAX + 1);

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_QUEUE  = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [2:0] KIND_LOOKUP    = 3'd0;
    localparam logic [2:0] KIND_QUEUED    = 3'd1;
    localparam logic [2:0] KIND_INSERTED  = 3'd2;
    localparam logic [2:0] KIND_RESEND    = 3'd3;
    localparam logic [2:0] KIND_GIVE_UP   = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;

    localparam logic [1:0] REG_CACHE_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT     = 2'd1;
    localparam logic [1:0] REG_RESEND_INTERVAL = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] ip;
        logic [47:0] mac;
    } arpc_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        hit;
        logic [47:0] found_mac;
        logic [31:0] event_ip;
        logic        full_res;
        logic        last;
    } arpc_out_t;

endpackage

`default_nettype wire

>>> sv/arpc_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

>>> sv/arp_cache_with_request_retry.sv
// Top level of the ARP cache with pending request table and retry sequencer.
// Lookup beats scan the cache table, queue and insert beats the pending table, one entry
// per cycle, before their result is given; a tick ages the cache table, then handles
// each due pending request, waiting on output stalls, before its own result; one item is
// in work at a time, and the next is accepted the cycle after its final result is loaded.
// Reset clears valid bits, send counts and seconds and loads 15, 5 and 1; RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "arp_cache_with_request_retry_defines.svh"

module arp_cache_with_request_retry
    import arpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire arpc_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output arpc_out_t      out_data,
    input  wire logic      cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [15:0] cfg_wdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_PRD  = 3'd2;
    localparam logic [2:0] S_PEV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        state_reg;
    logic [1:0]        op_reg;
    logic [31:0]       ip_reg;
    logic [47:0]       mac_reg;
    logic [47:0]       fm_reg;
    logic              hit_reg;
    logic [SCAN_W-1:0] idx_reg;
    logic [SCAN_W-1:0] eidx_reg;
    logic              rdv_reg;
    logic [31:0]       now_reg;
    logic [15:0]       timeout_reg;
    logic [3:0]        retry_reg;
    logic [7:0]        interval_reg;
    logic [CACHE_ENTRIES-1:0] cache_valid_reg;
    logic [PEND_ENTRIES-1:0]  pend_valid_reg;
    logic [3:0]        pend_count_reg [PEND_ENTRIES];
    logic              out_valid_reg;
    arpc_out_t         out_reg;
    arpc_out_t         out_next;

    logic [31:0] caddr_rdata;
    logic [47:0] chw_rdata;
    logic [31:0] cadd_rdata;
    logic [31:0] paddr_rdata;
    logic [31:0] psent_rdata;

    logic [SCAN_W-1:0] scan_end;
    logic [CIDX_W-1:0] ce;
    logic [PIDX_W-1:0] pe;
    logic [PIDX_W-1:0] pi;
    logic [31:0] stamp_sel;
    logic [31:0] lim_sel;
    logic [31:0] elapsed;
    logic        over;
    logic [31:0] cmp_addr;
    logic        addr_eq;
    logic        cfree_found;
    logic [CIDX_W-1:0] cfree_idx;
    logic        pfree_found;
    logic [PIDX_W-1:0] pfree_idx;
    logic        in_accept;
    logic        can_emit;
    logic        done_emit;
    logic        pev_due;
    logic        pev_giveup;
    logic        pev_emit;
    logic        out_load;
    logic        cache_we;
    logic        paddr_we;
    logic        psent_we;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign can_emit  = !out_valid_reg || !out_stall;

    assign scan_end = (op_reg inside {CMD_LOOKUP, CMD_TICK}) ? SCAN_W'(CACHE_ENTRIES)
                                                             : SCAN_W'(PEND_ENTRIES);
    assign ce = eidx_reg[CIDX_W-1:0];
    assign pe = eidx_reg[PIDX_W-1:0];
    assign pi = idx_reg[PIDX_W-1:0];

    // Shared age comparator: cache aging during the scan, resend timing afterwards.
    assign stamp_sel = (state_reg == S_SCAN) ? cadd_rdata : psent_rdata;
    assign lim_sel   = (state_reg == S_SCAN) ? {16'd0, timeout_reg} : {24'd0, interval_reg};
    assign elapsed   = now_reg - stamp_sel;
    assign over      = elapsed > lim_sel;

    // Shared address comparator.
    assign cmp_addr = (op_reg == CMD_LOOKUP) ? caddr_rdata : paddr_rdata;
    assign addr_eq  = (cmp_addr == ip_reg);

    always_comb
    begin
        cfree_found = 1'b0;
        cfree_idx   = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!cache_valid_reg[i])
            begin
                cfree_found = 1'b1;
                cfree_idx   = CIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        pfree_found = 1'b0;
        pfree_idx   = '0;
        for (int i = PEND_ENTRIES - 1; i >= 0; i--)
        begin
            if (!pend_valid_reg[i])
            begin
                pfree_found = 1'b1;
                pfree_idx   = PIDX_W'(i);
            end
        end
    end

    assign pev_due    = pend_valid_reg[pi] && ((pend_count_reg[pi] == 4'd0) || over);
    assign pev_giveup = pend_count_reg[pi] >= retry_reg;
    assign pev_emit   = (state_reg == S_PEV) && pev_due && can_emit;
    assign done_emit  = (state_reg == S_DONE) && can_emit;
    assign out_load   = pev_emit || done_emit;

    assign cache_we = done_emit && (op_reg == CMD_INSERT) && cfree_found;
    assign paddr_we = done_emit && (op_reg == CMD_QUEUE) && !hit_reg && pfree_found;
    assign psent_we = pev_emit && !pev_giveup;

    always_comb
    begin
        out_next = '0;
        if (state_reg == S_PEV)
        begin
            out_next.kind     = pev_giveup ? KIND_GIVE_UP : KIND_RESEND;
            out_next.event_ip = paddr_rdata;
        end
        else
        begin
            out_next.last = 1'b1;
            unique case (op_reg)
                CMD_LOOKUP:
                begin
                    out_next.kind      = KIND_LOOKUP;
                    out_next.hit       = hit_reg;
                    out_next.found_mac = fm_reg;
                end
                CMD_QUEUE:
                begin
                    out_next.kind     = KIND_QUEUED;
                    out_next.full_res = !hit_reg && !pfree_found;
                end
                CMD_INSERT:
                begin
                    out_next.kind     = KIND_INSERTED;
                    out_next.hit      = hit_reg;
                    out_next.full_res = !cfree_found;
                end
                default:
                begin
                    out_next.kind = KIND_TICK_DONE;
                end
            endcase
        end
    end

    arpc_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_cache_addr (
        .clk   (clk),
        .we    (cache_we),
        .waddr (cfree_idx),
        .wdata (ip_reg),
        .raddr (idx_reg[CIDX_W-1:0]),
        .rdata (caddr_rdata)
    );

    arpc_ram #(.WIDTH(48), .DEPTH(CACHE_ENTRIES)) u_cache_hw (
        .clk   (clk),
        .we    (cache_we),
        .waddr (cfree_idx),
        .wdata (mac_reg),
        .raddr (idx_reg[CIDX_W-1:0]),
        .rdata (chw_rdata)
    );

    arpc_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_cache_added (
        .clk   (clk),
        .we    (cache_we),
        .waddr (cfree_idx),
        .wdata (now_reg),
        .raddr (idx_reg[CIDX_W-1:0]),
        .rdata (cadd_rdata)
    );

    arpc_ram #(.WIDTH(32), .DEPTH(PEND_ENTRIES)) u_pend_addr (
        .clk   (clk),
        .we    (paddr_we),
        .waddr (pfree_idx),
        .wdata (ip_reg),
        .raddr (pi),
        .rdata (paddr_rdata)
    );

    arpc_ram #(.WIDTH(32), .DEPTH(PEND_ENTRIES)) u_pend_sent (
        .clk   (clk),
        .we    (psent_we),
        .waddr (pi),
        .wdata (now_reg),
        .raddr (pi),
        .rdata (psent_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= CMD_LOOKUP;
            hit_reg         <= 1'b0;
            idx_reg         <= '0;
            eidx_reg        <= '0;
            rdv_reg         <= 1'b0;
            now_reg         <= '0;
            timeout_reg     <= 16'd15;
            retry_reg       <= 4'd5;
            interval_reg    <= 8'd1;
            cache_valid_reg <= '0;
            pend_valid_reg  <= '0;
            for (int i = 0; i < PEND_ENTRIES; i++)
            begin
                pend_count_reg[i] <= 4'd0;
            end
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_CACHE_TIMEOUT:   timeout_reg  <= cfg_wdata;
                    REG_RETRY_LIMIT:     retry_reg    <= cfg_wdata[3:0];
                    REG_RESEND_INTERVAL: interval_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_SCAN;
                        op_reg    <= in_data.cmd;
                        idx_reg   <= '0;
                        rdv_reg   <= 1'b0;
                        hit_reg   <= 1'b0;
                        if (in_data.cmd == CMD_TICK)
                        begin
                            now_reg <= now_reg + 32'd1;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg != scan_end)
                    begin
                        idx_reg <= idx_reg + SCAN_W'(1);
                    end
                    rdv_reg  <= (idx_reg != scan_end);
                    eidx_reg <= idx_reg;
                    if (rdv_reg)
                    begin
                        unique case (op_reg)
                            CMD_LOOKUP:
                            begin
                                if (cache_valid_reg[ce] && addr_eq)
                                begin
                                    hit_reg <= 1'b1;
                                end
                            end
                            CMD_QUEUE:
                            begin
                                if (pend_valid_reg[pe] && addr_eq)
                                begin
                                    hit_reg <= 1'b1;
                                end
                            end
                            CMD_INSERT:
                            begin
                                if (pend_valid_reg[pe] && addr_eq && !hit_reg)
                                begin
                                    pend_valid_reg[pe] <= 1'b0;
                                    pend_count_reg[pe] <= 4'd0;
                                    hit_reg            <= 1'b1;
                                end
                            end
                            default:
                            begin
                                if (cache_valid_reg[ce] && over)
                                begin
                                    cache_valid_reg[ce] <= 1'b0;
                                end
                            end
                        endcase
                    end
                    if ((idx_reg == scan_end) && !rdv_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= (op_reg == CMD_TICK) ? S_PRD : S_DONE;
                    end
                end
                S_PRD:
                begin
                    state_reg <= (idx_reg == SCAN_W'(PEND_ENTRIES)) ? S_DONE : S_PEV;
                end
                S_PEV:
                begin
                    if (!pev_due)
                    begin
                        idx_reg   <= idx_reg + SCAN_W'(1);
                        state_reg <= S_PRD;
                    end
                    else if (can_emit)
                    begin
                        if (pev_giveup)
                        begin
                            pend_valid_reg[pi] <= 1'b0;
                            pend_count_reg[pi] <= 4'd0;
                        end
                        else
                        begin
                            pend_count_reg[pi] <= pend_count_reg[pi] + 4'd1;
                        end
                        idx_reg   <= idx_reg + SCAN_W'(1);
                        state_reg <= S_PRD;
                    end
                end
                S_DONE:
                begin
                    if (can_emit)
                    begin
                        state_reg <= S_IDLE;
                        if (paddr_we)
                        begin
                            pend_valid_reg[pfree_idx] <= 1'b1;
                            pend_count_reg[pfree_idx] <= 4'd0;
                        end
                        if (cache_we)
                        begin
                            cache_valid_reg[cfree_idx] <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ip_reg  <= in_data.ip;
            mac_reg <= in_data.mac;
            fm_reg  <= '0;
        end
        else if ((state_reg == S_SCAN) && rdv_reg && (op_reg == CMD_LOOKUP) &&
                 cache_valid_reg[ce] && addr_eq)
        begin
            fm_reg <= chw_rdata;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    `ARPC_ASSERT_NOW(a_not_last_kind, out_valid_reg && !out_reg.last,
        out_reg.kind == KIND_RESEND || out_reg.kind == KIND_GIVE_UP,
        "A beat that is not last must be a resend or give-up.")

    `ARPC_ASSERT_NOW(a_miss_zero_mac, out_valid_reg && out_reg.kind == KIND_LOOKUP && !out_reg.hit,
        out_reg.found_mac == 48'd0,
        "A lookup miss must carry a zero MAC.")

    `ARPC_ASSERT_NOW(a_queue_no_hit, out_valid_reg && out_reg.kind == KIND_QUEUED,
        !out_reg.hit,
        "A queue result must not report a hit.")

    `ARPC_ASSERT_NEXT(a_busy_after_accept, in_accept,
        state_reg == S_SCAN,
        "An accepted beat must start the scan.")

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the ARP cache with pending request retry table.
`timescale 1ns / 1ps

module tb_top;
    import arpc_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 300;

    class arp_mirror;
        logic [31:0] c_ip[CACHE_ENTRIES];
        logic [47:0] c_mac[CACHE_ENTRIES];
        bit          c_ok[CACHE_ENTRIES];
        logic [31:0] c_born[CACHE_ENTRIES];
        logic [31:0] q_ip[PEND_ENTRIES];
        bit          q_ok[PEND_ENTRIES];
        logic [31:0] q_sent[PEND_ENTRIES];
        logic [3:0]  q_tries[PEND_ENTRIES];
        logic [31:0] seconds;
        logic [15:0] age_limit;
        logic [3:0]  try_limit;
        logic [7:0]  gap_secs;
        arpc_out_t   due_results[$];
        int unsigned mismatches, beats_checked, cmds_taken;
        int unsigned n_hits, n_resends, n_give_ups, n_full;

        function new();
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                c_ip[i] = '0;
                c_mac[i] = '0;
                c_ok[i] = 1'b0;
                c_born[i] = '0;
            end
            for (int i = 0; i < PEND_ENTRIES; i++) begin
                q_ip[i] = '0;
                q_ok[i] = 1'b0;
                q_sent[i] = '0;
                q_tries[i] = '0;
            end
            seconds = '0;
            age_limit = 16'd15;
            try_limit = 4'd5;
            gap_secs = 8'd1;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_CACHE_TIMEOUT:   age_limit = val;
                REG_RETRY_LIMIT:     try_limit = val[3:0];
                REG_RESEND_INTERVAL: gap_secs = val[7:0];
                default: ;
            endcase
        endfunction

        function void add_result(logic [2:0] kind, logic hit, logic [47:0] mac,
                                 logic [31:0] ip, logic full, logic last);
            arpc_out_t r;
            r.kind = kind;
            r.hit = hit;
            r.found_mac = mac;
            r.event_ip = ip;
            r.full_res = full;
            r.last = last;
            due_results.push_back(r);
            if (hit) n_hits++;
            if (full) n_full++;
            if (kind == KIND_RESEND) n_resends++;
            if (kind == KIND_GIVE_UP) n_give_ups++;
        endfunction

        function void accept_cmd(arpc_in_t b);
            bit          found;
            logic [47:0] m;
            int          slot;
            bit          due;
            cmds_taken++;
            found = 1'b0;
            m = '0;
            slot = -1;
            case (b.cmd)
                CMD_LOOKUP:
                begin
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                        if (c_ok[i] && c_ip[i] == b.ip)
                        begin
                            found = 1'b1;
                            m = c_mac[i];
                        end
                    add_result(KIND_LOOKUP, found, m, '0, 1'b0, 1'b1);
                end
                CMD_QUEUE:
                begin
                    for (int i = 0; i < PEND_ENTRIES; i++)
                    begin
                        if (q_ok[i] && q_ip[i] == b.ip) found = 1'b1;
                        if (!q_ok[i] && slot < 0) slot = i;
                    end
                    if (!found && slot >= 0)
                    begin
                        q_ip[slot] = b.ip;
                        q_ok[slot] = 1'b1;
                        q_sent[slot] = '0;
                        q_tries[slot] = '0;
                    end
                    add_result(KIND_QUEUED, 1'b0, '0, '0, !found && slot < 0, 1'b1);
                end
                CMD_INSERT:
                begin
                    for (int i = 0; i < PEND_ENTRIES; i++)
                        if (q_ok[i] && q_ip[i] == b.ip && !found)
                        begin
                            q_ok[i] = 1'b0;
                            q_tries[i] = '0;
                            found = 1'b1;
                        end
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                        if (!c_ok[i] && slot < 0) slot = i;
                    if (slot >= 0)
                    begin
                        c_ip[slot] = b.ip;
                        c_mac[slot] = b.mac;
                        c_born[slot] = seconds;
                        c_ok[slot] = 1'b1;
                    end
                    add_result(KIND_INSERTED, found, '0, '0, slot < 0, 1'b1);
                end
                default:
                begin
                    seconds = seconds + 32'd1;
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                        if (c_ok[i] && (seconds - c_born[i]) > {16'd0, age_limit})
                            c_ok[i] = 1'b0;
                    for (int i = 0; i < PEND_ENTRIES; i++)
                    begin
                        if (!q_ok[i]) continue;
                        due = (q_tries[i] == 4'd0) || ((seconds - q_sent[i]) > {24'd0, gap_secs});
                        if (!due) continue;
                        if (q_tries[i] >= try_limit)
                        begin
                            q_ok[i] = 1'b0;
                            q_tries[i] = '0;
                            add_result(KIND_GIVE_UP, 1'b0, '0, q_ip[i], 1'b0, 1'b0);
                        end
                        else
                        begin
                            q_sent[i] = seconds;
                            q_tries[i] = q_tries[i] + 4'd1;
                            add_result(KIND_RESEND, 1'b0, '0, q_ip[i], 1'b0, 1'b0);
                        end
                    end
                    add_result(KIND_TICK_DONE, 1'b0, '0, '0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string tag, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
                mismatches++;
            end
        endfunction

        function void check_reply(arpc_out_t got);
            arpc_out_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: result beat with none expected, expected nothing, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            beats_checked++;
            compare_field("kind", 64'(want.kind), 64'(got.kind));
            compare_field("hit", 64'(want.hit), 64'(got.hit));
            compare_field("found_mac", 64'(want.found_mac), 64'(got.found_mac));
            compare_field("event_ip", 64'(want.event_ip), 64'(got.event_ip));
            compare_field("full_res", 64'(want.full_res), 64'(got.full_res));
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    arpc_in_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    arpc_out_t   out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [15:0] cfg_wdata = '0;

    arp_mirror   mirror = new();
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    arp_cache_with_request_retry DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            mirror.check_reply(out_data);
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 17);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("arp_cache_with_request_retry regression: fail");
            $finish;
        end
    end

    function automatic arpc_in_t make_cmd(logic [1:0] cmd, logic [31:0] ip, logic [47:0] mac);
        arpc_in_t b;
        b.cmd = cmd;
        b.ip = ip;
        b.mac = mac;
        return b;
    endfunction

    // Addresses mostly come from a small pool so that hits, duplicates and full tables occur.
    function automatic arpc_in_t random_cmd(int mix);
        arpc_in_t b;
        int       r;
        r = $urandom_range(99);
        case (mix)
            0:       b.cmd = (r < 30) ? CMD_LOOKUP : (r < 55) ? CMD_QUEUE :
                             (r < 80) ? CMD_INSERT : CMD_TICK;
            1:       b.cmd = (r < 10) ? CMD_LOOKUP : (r < 50) ? CMD_QUEUE :
                             (r < 60) ? CMD_INSERT : CMD_TICK;
            default: b.cmd = (r < 30) ? CMD_LOOKUP : (r < 40) ? CMD_QUEUE :
                             (r < 85) ? CMD_INSERT : CMD_TICK;
        endcase
        if ($urandom_range(99) < 85)
            b.ip = 32'hC0A80100 | $urandom_range(11);
        else
            b.ip = $urandom();
        b.mac[47:32] = 16'($urandom_range(16'hFFFF));
        b.mac[31:0] = $urandom();
        return b;
    endfunction

    task automatic send_beat(input arpc_in_t b);
        if (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        mirror.accept_cmd(b);
    endtask

    task automatic send_random(input int count, input int mix);
        repeat (count) send_beat(random_cmd(mix));
        in_valid <= 1'b0;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        mirror.write_reg(idx, val);
    endtask

    task automatic cfg_done();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (mirror.due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_beat(make_cmd(CMD_LOOKUP, 32'h0, 48'h0));
        send_beat(make_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0));
        send_beat(make_cmd(CMD_INSERT, 32'h0, 48'h0));
        send_beat(make_cmd(CMD_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
        send_beat(make_cmd(CMD_LOOKUP, 32'h0, 48'h0));
        send_beat(make_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0));
        send_beat(make_cmd(CMD_INSERT, 32'hC0A8_0105, 48'h0011_2233_4455));
        send_beat(make_cmd(CMD_INSERT, 32'hC0A8_0105, 48'hAABB_CCDD_EEFF));
        send_beat(make_cmd(CMD_LOOKUP, 32'hC0A8_0105, 48'h0));
        send_beat(make_cmd(CMD_QUEUE, 32'hC0A8_0106, 48'h0));
        send_beat(make_cmd(CMD_QUEUE, 32'hC0A8_0106, 48'h0));
        send_beat(make_cmd(CMD_QUEUE, 32'hC0A8_0107, 48'h0));
        repeat (3) send_beat(make_cmd(CMD_TICK, 32'h0, 48'h0));
        send_beat(make_cmd(CMD_INSERT, 32'hC0A8_0106, 48'h0000_0000_0106));
        for (int k = 0; k < PEND_ENTRIES; k++)
            send_beat(make_cmd(CMD_QUEUE, 32'hC0A8_0110 + k, 48'h0));
        send_beat(make_cmd(CMD_TICK, 32'h0, 48'h0));
        in_valid <= 1'b0;
        drain();

        // Retry limit of zero abandons every due request on the spot.
        cfg_write(REG_CACHE_TIMEOUT, 16'd1);
        cfg_write(REG_RETRY_LIMIT, 16'd0);
        cfg_write(REG_RESEND_INTERVAL, 16'd255);
        cfg_write(REG_UNUSED, 16'hFFFF);
        cfg_done();
        send_beat(make_cmd(CMD_TICK, 32'h0, 48'h0));
        send_beat(make_cmd(CMD_INSERT, 32'hC0A8_0110, 48'h0));
        send_beat(make_cmd(CMD_QUEUE, 32'hC0A8_0120, 48'h0));
        send_beat(make_cmd(CMD_TICK, 32'h0, 48'h0));
        send_random(15, 1);
        drain();

        cfg_write(REG_CACHE_TIMEOUT, 16'hFFFF);
        cfg_write(REG_RETRY_LIMIT, 16'd15);
        cfg_write(REG_RESEND_INTERVAL, 16'd1);
        cfg_done();
        calm = 1'b1;
        send_random(35, 1);
        calm = 1'b0;
        drain();

        cfg_write(REG_CACHE_TIMEOUT, 16'd7);
        cfg_write(REG_RETRY_LIMIT, 16'd2);
        cfg_write(REG_RESEND_INTERVAL, 16'd3);
        cfg_done();
        hold_req = 1'b1;
        send_random(45, 0);
        drain();

        cfg_write(REG_CACHE_TIMEOUT, 16'hFFFF);
        cfg_write(REG_RETRY_LIMIT, 16'hABC1);
        cfg_write(REG_RESEND_INTERVAL, 16'h5A01);
        cfg_done();
        send_random(35, 2);
        drain();
        repeat (60) @(posedge clk);

        $display("Covered %0d commands over five register settings, %0d result beats checked.",
                 mirror.cmds_taken, mirror.beats_checked);
        $display("Seen %0d hits, %0d resends, %0d give-ups and %0d full-table results.",
                 mirror.n_hits, mirror.n_resends, mirror.n_give_ups, mirror.n_full);
        if (mirror.mismatches == 0 && mirror.due_results.size() == 0)
            $display("arp_cache_with_request_retry regression: pass");
        else
            $display("arp_cache_with_request_retry regression: fail");
        $finish;
    end

endmodule

>>> arp_cache_with_request_retry.f
+incdir+sv
sv/arpc_pkg.sv
sv/arpc_ram.sv
sv/arp_cache_with_request_retry.sv
dv/tb_top.sv
